### rtl/core/websocket_frame_parser_macros.svh
// assertion macros for the frame parser rtl, used by wsfp_parse
`ifndef WEBSOCKET_FRAME_PARSER_MACROS_SVH
`define WEBSOCKET_FRAME_PARSER_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define WSFP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("wsfp assertion failed");

// antecedent implies consequent in the next cycle
`define WSFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("wsfp assertion failed");

`else

`define WSFP_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define WSFP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/core/wsfp_pkg.sv
// package: opcodes, result kinds and the result word type of the frame parser
`default_nettype none

package wsfp_pkg;

    localparam int unsigned LenWidth = 64;

    localparam logic [3:0] OPC_TEXT   = 4'h1;
    localparam logic [3:0] OPC_BINARY = 4'h2;
    localparam logic [3:0] OPC_CLOSE  = 4'h8;
    localparam logic [3:0] OPC_PING   = 4'h9;
    localparam logic [3:0] OPC_PONG   = 4'hA;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_PING  = 2'd1;
    localparam logic [1:0] KIND_CLOSE = 2'd2;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    typedef struct packed {
        logic       emit;
        logic [1:0] kind;
        logic [7:0] payload_byte;
        logic       has_byte;
        logic       last;
    } t_result;

endpackage

`default_nettype wire

### rtl/core/wsfp_parse.sv
// frame header parser and payload counter, one word per advance
`default_nettype none

`include "websocket_frame_parser_macros.svh"

module wsfp_parse (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_go,
    input  wire logic [7:0]        i_byte,
    output wsfp_pkg::t_result      o_res
);

    localparam logic [2:0] PH_HDR0   = 3'd0;
    localparam logic [2:0] PH_HDR1   = 3'd1;
    localparam logic [2:0] PH_EXTLEN = 3'd2;
    localparam logic [2:0] PH_MASK   = 3'd3;
    localparam logic [2:0] PH_DATA   = 3'd4;
    localparam logic [2:0] PH_CLOSED = 3'd5;

    localparam int unsigned LW = wsfp_pkg::LenWidth;

    logic [2:0]    r_phase,    n_phase;
    logic [3:0]    r_opcode,   n_opcode;
    logic          r_mask,     n_mask;
    logic [3:0]    r_hdr_left, n_hdr_left;
    logic [LW-1:0] r_len,      n_len;

    logic              len_done;
    logic              pay_start;
    logic              fin;
    logic [6:0]        len7;
    wsfp_pkg::t_result res;

    always_comb begin
        n_phase    = r_phase;
        n_opcode   = r_opcode;
        n_mask     = r_mask;
        n_hdr_left = r_hdr_left;
        n_len      = r_len;
        len_done   = 1'b0;
        pay_start  = 1'b0;
        fin        = 1'b0;
        len7       = i_byte[6:0];
        res        = '0;

        case (r_phase)
            PH_HDR0: begin
                n_opcode = i_byte[3:0];
                n_phase  = PH_HDR1;
            end
            PH_HDR1: begin
                n_mask = i_byte[7];
                if (len7 == wsfp_pkg::LEN7_EXT16 || len7 == wsfp_pkg::LEN7_EXT64) begin
                    n_hdr_left = (len7 == wsfp_pkg::LEN7_EXT16) ? 4'd2 : 4'd8;
                    n_len      = '0;
                    n_phase    = PH_EXTLEN;
                end else begin
                    n_len    = LW'(len7);
                    len_done = 1'b1;
                end
            end
            PH_EXTLEN: begin
                n_len      = {r_len[LW-9:0], i_byte};
                n_hdr_left = r_hdr_left - 4'd1;
                len_done   = (n_hdr_left == 4'd0);
            end
            PH_MASK: begin
                n_hdr_left = r_hdr_left - 4'd1;
                pay_start  = (n_hdr_left == 4'd0);
            end
            PH_DATA: begin
                // the counter never sits at zero here, so one left means this is the end
                fin   = (r_len == LW'(1));
                n_len = r_len - LW'(1);
                if (fin) begin
                    n_phase = PH_HDR0;
                end
                if (r_opcode == wsfp_pkg::OPC_TEXT || r_opcode == wsfp_pkg::OPC_BINARY) begin
                    res = '{emit: 1'b1, kind: wsfp_pkg::KIND_DATA, payload_byte: i_byte,
                            has_byte: 1'b1, last: fin};
                end else if (r_opcode == wsfp_pkg::OPC_PING) begin
                    res = '{emit: 1'b1, kind: wsfp_pkg::KIND_PING, payload_byte: i_byte,
                            has_byte: 1'b1, last: fin};
                end else if (r_opcode == wsfp_pkg::OPC_CLOSE && fin) begin
                    n_phase = PH_CLOSED;
                    res = '{emit: 1'b1, kind: wsfp_pkg::KIND_CLOSE, payload_byte: 8'd0,
                            has_byte: 1'b0, last: 1'b1};
                end
            end
            default: begin
                // closed, and unused codes behave the same
            end
        endcase

        if (len_done) begin
            if (n_mask) begin
                n_hdr_left = 4'd4;
                n_phase    = PH_MASK;
            end else begin
                pay_start = 1'b1;
            end
        end

        if (pay_start) begin
            if (n_len != '0) begin
                n_phase = PH_DATA;
            end else begin
                n_phase = PH_HDR0;
                if (r_opcode == wsfp_pkg::OPC_TEXT || r_opcode == wsfp_pkg::OPC_BINARY) begin
                    res = '{emit: 1'b1, kind: wsfp_pkg::KIND_DATA, payload_byte: 8'd0,
                            has_byte: 1'b0, last: 1'b1};
                end else if (r_opcode == wsfp_pkg::OPC_PING) begin
                    res = '{emit: 1'b1, kind: wsfp_pkg::KIND_PING, payload_byte: 8'd0,
                            has_byte: 1'b0, last: 1'b1};
                end else if (r_opcode == wsfp_pkg::OPC_CLOSE) begin
                    n_phase = PH_CLOSED;
                    res = '{emit: 1'b1, kind: wsfp_pkg::KIND_CLOSE, payload_byte: 8'd0,
                            has_byte: 1'b0, last: 1'b1};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HDR0;
            r_opcode   <= '0;
            r_mask     <= 1'b0;
            r_hdr_left <= '0;
            r_len      <= '0;
        end else if (i_go) begin
            r_phase    <= n_phase;
            r_opcode   <= n_opcode;
            r_mask     <= n_mask;
            r_hdr_left <= n_hdr_left;
            r_len      <= n_len;
        end
    end

    assign o_res = i_go ? res : '0;

    `WSFP_ASSERT_SAME(a_empty_is_last, i_clk, i_rst_n, o_res.emit && !o_res.has_byte, o_res.last)
    `WSFP_ASSERT_SAME(a_close_no_byte, i_clk, i_rst_n,
        o_res.emit && o_res.kind == wsfp_pkg::KIND_CLOSE, !o_res.has_byte)
    `WSFP_ASSERT_NEXT(a_closed_sticks, i_clk, i_rst_n, r_phase == PH_CLOSED, r_phase == PH_CLOSED)
    `WSFP_ASSERT_SAME(a_hdr_count_live, i_clk, i_rst_n,
        r_phase == PH_EXTLEN || r_phase == PH_MASK, r_hdr_left != 4'd0)
    `WSFP_ASSERT_SAME(a_data_len_live, i_clk, i_rst_n, r_phase == PH_DATA, r_len != '0)

endmodule

`default_nettype wire

### rtl/core/wsfp_out_reg.sv
// result register on the output channel
`default_nettype none

module wsfp_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_go,
    input  wire wsfp_pkg::t_result i_res,
    input  wire logic              i_stall,
    output logic                   o_free,
    output logic                   o_valid,
    output logic [1:0]             o_kind,
    output logic [7:0]             o_payload_byte,
    output logic                   o_has_byte,
    output logic                   o_last
);

    logic              r_valid;
    wsfp_pkg::t_result r_res;

    // a new word may land when the register is empty or is taken this cycle
    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_go) begin
            r_valid <= i_res.emit;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go && i_res.emit) begin
            r_res <= i_res;
        end
    end

    assign o_valid        = r_valid;
    assign o_kind         = r_res.kind;
    assign o_payload_byte = r_res.payload_byte;
    assign o_has_byte     = r_res.has_byte;
    assign o_last         = r_res.last;

endmodule

`default_nettype wire

### rtl/core/websocket_frame_parser.sv
// top level of the websocket receive frame parser
// Takes one received stream byte per word and gives at most one result word per byte.
// A byte is taken every clock while results drain; a byte that produces a result
// passes the input register, then the result register, before it shows on the
// output, and waits in the input register while a stalled result blocks it. The
// parse of each byte, including the 64-bit length countdown, fits in the single
// logic stage between those two registers. Mask keys are skipped and the payload
// is not unmasked. After a close frame ends, all input is dropped until reset.
`default_nettype none

module websocket_frame_parser (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [1:0]      o_kind,
    output logic [7:0]      o_payload_byte,
    output logic            o_has_byte,
    output logic            o_last
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              out_free;
    logic              advance;
    wsfp_pkg::t_result res;

    assign advance = r_in_valid && out_free;
    assign o_stall = r_in_valid && !out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    wsfp_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (advance),
        .i_byte  (r_in_byte),
        .o_res   (res)
    );

    wsfp_out_reg u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_go           (advance),
        .i_res          (res),
        .i_stall        (i_stall),
        .o_free         (out_free),
        .o_valid        (o_valid),
        .o_kind         (o_kind),
        .o_payload_byte (o_payload_byte),
        .o_has_byte     (o_has_byte),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire

### verif/tb_websocket_frame_parser.sv
`timescale 1ns / 1ps
// self-checking testbench for the websocket frame parser: frame stimulus, parse predictor, checks

module tb_websocket_frame_parser;

    localparam logic [3:0] OPC_CONT           = 4'h0;
    localparam logic [3:0] OPC_RSVD_DATA_LO   = 4'h3;
    localparam logic [3:0] OPC_RSVD_DATA_HI   = 4'h7;
    localparam logic [3:0] OPC_RSVD_CTRL_LO   = 4'hB;
    localparam logic [3:0] OPC_RSVD_CTRL_HI   = 4'hF;

    localparam int unsigned ITEM_TARGET   = 1300;
    localparam int unsigned CLOSE_RESERVE = 60;
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned DRAIN_CYCLES  = 12;
    localparam int unsigned PRINT_LIMIT   = 30;

    typedef enum logic [2:0] {
        PH_HEAD0,
        PH_HEAD1,
        PH_EXTLEN,
        PH_MASKKEY,
        PH_PAYLOAD,
        PH_CLOSED
    } t_parse_phase;

    typedef enum logic [1:0] {
        LF_SHORT,
        LF_EXT16,
        LF_EXT64
    } t_len_form;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] payload_byte;
        logic       has_byte;
        logic       last;
    } t_out_word;

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       i_valid   = 1'b0;
    logic [7:0] i_rx_byte = 8'd0;
    logic       i_stall   = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [1:0] o_kind;
    logic [7:0] o_payload_byte;
    logic       o_has_byte;
    logic       o_last;

    // parser state mirrored by the predictor
    t_parse_phase ps_phase    = PH_HEAD0;
    logic [3:0]   ps_opcode   = 4'd0;
    logic         ps_masked   = 1'b0;
    logic [3:0]   ps_hdr_left = 4'd0;
    logic [63:0]  ps_len      = 64'd0;
    logic [63:0]  ps_left     = 64'd0;

    t_out_word expected_words[$];
    t_out_word head_word;

    bit          tx_idle_on    = 1'b1;
    bit          rx_idle_on    = 1'b1;
    int unsigned err_count     = 0;
    int unsigned words_checked = 0;
    int unsigned bytes_sent    = 0;
    int unsigned frames_sent   = 0;
    int unsigned cycle_count   = 0;

    websocket_frame_parser dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_kind         (o_kind),
        .o_payload_byte (o_payload_byte),
        .o_has_byte     (o_has_byte),
        .o_last         (o_last)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still awaited",
                     cycle_count, expected_words.size());
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_stall <= rx_idle_on && ($urandom_range(0, 99) < 33);
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic report_mismatch(input string msg);
        if (err_count < PRINT_LIMIT) begin
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        end
        err_count++;
    endtask

    task automatic queue_word(input logic [1:0] kind, input logic [7:0] pb,
                              input logic has, input logic fin);
        t_out_word w;
        w.kind         = kind;
        w.payload_byte = pb;
        w.has_byte     = has;
        w.last         = fin;
        expected_words.push_back(w);
    endtask

    // header done: enter the payload, or close out an empty frame right away
    task automatic start_payload();
        ps_left = ps_len;
        if (ps_left != 64'd0) begin
            ps_phase = PH_PAYLOAD;
        end else begin
            ps_phase = PH_HEAD0;
            if (ps_opcode == wsfp_pkg::OPC_TEXT || ps_opcode == wsfp_pkg::OPC_BINARY) begin
                queue_word(wsfp_pkg::KIND_DATA, 8'd0, 1'b0, 1'b1);
            end else if (ps_opcode == wsfp_pkg::OPC_PING) begin
                queue_word(wsfp_pkg::KIND_PING, 8'd0, 1'b0, 1'b1);
            end else if (ps_opcode == wsfp_pkg::OPC_CLOSE) begin
                ps_phase = PH_CLOSED;
                queue_word(wsfp_pkg::KIND_CLOSE, 8'd0, 1'b0, 1'b1);
            end
        end
    endtask

    task automatic finish_length();
        if (ps_masked) begin
            ps_hdr_left = 4'd4;
            ps_phase    = PH_MASKKEY;
        end else begin
            start_payload();
        end
    endtask

    task automatic parse_byte(input logic [7:0] b);
        logic [6:0] len7;
        logic       fin;
        case (ps_phase)
            PH_HEAD0: begin
                ps_opcode = b[3:0];
                ps_phase  = PH_HEAD1;
            end
            PH_HEAD1: begin
                ps_masked = b[7];
                len7      = b[6:0];
                if (len7 == wsfp_pkg::LEN7_EXT16 || len7 == wsfp_pkg::LEN7_EXT64) begin
                    ps_hdr_left = (len7 == wsfp_pkg::LEN7_EXT16) ? 4'd2 : 4'd8;
                    ps_len      = 64'd0;
                    ps_phase    = PH_EXTLEN;
                end else begin
                    ps_len = {57'd0, len7};
                    finish_length();
                end
            end
            PH_EXTLEN: begin
                ps_len      = {ps_len[55:0], b};
                ps_hdr_left = ps_hdr_left - 4'd1;
                if (ps_hdr_left == 4'd0) begin
                    finish_length();
                end
            end
            PH_MASKKEY: begin
                ps_hdr_left = ps_hdr_left - 4'd1;
                if (ps_hdr_left == 4'd0) begin
                    start_payload();
                end
            end
            PH_PAYLOAD: begin
                ps_left = ps_left - 64'd1;
                fin     = (ps_left == 64'd0);
                if (fin) begin
                    ps_phase = PH_HEAD0;
                end
                if (ps_opcode == wsfp_pkg::OPC_TEXT || ps_opcode == wsfp_pkg::OPC_BINARY) begin
                    queue_word(wsfp_pkg::KIND_DATA, b, 1'b1, fin);
                end else if (ps_opcode == wsfp_pkg::OPC_PING) begin
                    queue_word(wsfp_pkg::KIND_PING, b, 1'b1, fin);
                end else if (ps_opcode == wsfp_pkg::OPC_CLOSE && fin) begin
                    ps_phase = PH_CLOSED;
                    queue_word(wsfp_pkg::KIND_CLOSE, 8'd0, 1'b0, 1'b1);
                end
            end
            default: begin
                // closed: everything is dropped
            end
        endcase
    endtask

    // one word on the input channel; returns at the edge where it is taken
    task automatic push_byte(input logic [7:0] b);
        int unsigned gap;
        if (tx_idle_on && $urandom_range(0, 99) < 33) begin
            gap = $urandom_range(1, 4);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        parse_byte(b);
        bytes_sent++;
    endtask

    task automatic put_frame(input logic [3:0] opc, input bit masked,
                             input t_len_form form, input logic [63:0] len);
        logic [3:0] flags;
        // fin and rsv bits are random, the parser ignores them
        flags = 4'($urandom_range(0, 15));
        push_byte({flags, opc});
        case (form)
            LF_SHORT: begin
                push_byte({masked, len[6:0]});
            end
            LF_EXT16: begin
                push_byte({masked, wsfp_pkg::LEN7_EXT16});
                push_byte(len[15:8]);
                push_byte(len[7:0]);
            end
            default: begin
                push_byte({masked, wsfp_pkg::LEN7_EXT64});
                for (int i = 7; i >= 0; i--) push_byte(len[i*8 +: 8]);
            end
        endcase
        if (masked) begin
            repeat (4) push_byte(rand_byte());
        end
        for (longint unsigned n = 0; n < len; n++) push_byte(rand_byte());
        frames_sent++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word kind %0d byte %02h has %0d last %0d",
                                          o_kind, o_payload_byte, o_has_byte, o_last));
            end else begin
                head_word = expected_words.pop_front();
                if (o_kind !== head_word.kind)
                    report_mismatch($sformatf("kind got %0d want %0d",
                                              o_kind, head_word.kind));
                if (o_payload_byte !== head_word.payload_byte)
                    report_mismatch($sformatf("payload_byte got %02h want %02h",
                                              o_payload_byte, head_word.payload_byte));
                if (o_has_byte !== head_word.has_byte)
                    report_mismatch($sformatf("has_byte got %0d want %0d",
                                              o_has_byte, head_word.has_byte));
                if (o_last !== head_word.last)
                    report_mismatch($sformatf("last got %0d want %0d",
                                              o_last, head_word.last));
                words_checked++;
            end
        end
    end

    task automatic test_short_frames();
        put_frame(wsfp_pkg::OPC_TEXT, 1'b0, LF_SHORT, 64'd0);
        put_frame(wsfp_pkg::OPC_BINARY, 1'b1, LF_SHORT, 64'd3);
        put_frame(wsfp_pkg::OPC_PING, 1'b0, LF_SHORT, 64'd0);
        put_frame(wsfp_pkg::OPC_PING, 1'b1, LF_SHORT, 64'd2);
        put_frame(wsfp_pkg::OPC_PONG, 1'b1, LF_SHORT, 64'd2);
        put_frame(OPC_CONT, 1'b0, LF_SHORT, 64'd1);
        put_frame(OPC_RSVD_CTRL_HI, 1'b0, LF_SHORT, 64'd0);
        put_frame(OPC_RSVD_DATA_LO, 1'b1, LF_SHORT, 64'd1);
        put_frame(wsfp_pkg::OPC_TEXT, 1'b0, LF_SHORT, 64'd125);
    endtask

    task automatic test_extended_lengths();
        // empty frame whose header ends on the last mask key byte
        put_frame(wsfp_pkg::OPC_BINARY, 1'b1, LF_EXT16, 64'd0);
        put_frame(wsfp_pkg::OPC_TEXT, 1'b0, LF_EXT16, 64'h0102);
        put_frame(wsfp_pkg::OPC_PING, 1'b0, LF_EXT64, 64'd0);
        put_frame(wsfp_pkg::OPC_BINARY, 1'b1, LF_EXT64, 64'd3);
        put_frame(wsfp_pkg::OPC_PONG, 1'b0, LF_EXT16, 64'd5);
    endtask

    // a 64-bit form length past one byte, counted down with no idling on either side
    task automatic test_long_length();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        put_frame(wsfp_pkg::OPC_BINARY, 1'b0, LF_EXT64, 64'h0000_0000_0000_0105);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_random_frames();
        int unsigned start;
        int unsigned done;
        int unsigned pick;
        logic [3:0]  opc;
        bit          masked;
        t_len_form   form;
        logic [63:0] len;
        start = bytes_sent;
        done  = 0;
        while (bytes_sent < ITEM_TARGET - CLOSE_RESERVE) begin
            // stretch with no idling on either side early in the run
            tx_idle_on = !(done >= 100 && done < 250);
            rx_idle_on = tx_idle_on;
            pick = $urandom_range(0, 99);
            if (pick < 30)
                opc = wsfp_pkg::OPC_TEXT;
            else if (pick < 55)
                opc = wsfp_pkg::OPC_BINARY;
            else if (pick < 75)
                opc = wsfp_pkg::OPC_PING;
            else if (pick < 83)
                opc = wsfp_pkg::OPC_PONG;
            else if (pick < 90)
                opc = OPC_CONT;
            else if (pick < 95)
                opc = 4'($urandom_range(OPC_RSVD_DATA_LO, OPC_RSVD_DATA_HI));
            else
                opc = 4'($urandom_range(OPC_RSVD_CTRL_LO, OPC_RSVD_CTRL_HI));
            masked = 1'($urandom_range(0, 1));
            pick   = $urandom_range(0, 99);
            if (pick < 60) begin
                form = LF_SHORT;
                len  = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(100, 125))
                                                   : 64'($urandom_range(0, 12));
            end else if (pick < 85) begin
                form = LF_EXT16;
                len  = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(256, 300))
                                                   : 64'($urandom_range(0, 20));
            end else begin
                form = LF_EXT64;
                len  = 64'($urandom_range(0, 20));
            end
            put_frame(opc, masked, form, len);
            done = bytes_sent - start;
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // close is terminal, so this runs last: one close word, then silence
    task automatic test_close_frame();
        if ($urandom_range(0, 1))
            put_frame(wsfp_pkg::OPC_CLOSE, 1'b1, LF_EXT16, 64'd4);
        else
            put_frame(wsfp_pkg::OPC_CLOSE, 1'b0, LF_SHORT, 64'd0);
        put_frame(wsfp_pkg::OPC_TEXT, 1'b0, LF_SHORT, 64'd6);
        put_frame(wsfp_pkg::OPC_PING, 1'b1, LF_SHORT, 64'd0);
        repeat (40) push_byte(rand_byte());
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_short_frames();
        test_extended_lengths();
        test_long_length();
        test_random_frames();
        test_close_frame();
        i_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("sent %0d frames in %0d stream bytes, plain and masked, 7/16/64-bit lengths",
                 frames_sent, bytes_sent);
        $display("checked %0d result words, ending on a close frame; %0d mismatches",
                 words_checked, err_count);
        if (err_count == 0 && expected_words.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
